FILE: hw/rtl/swmm_pkg.sv
// ----------------------------------------------------------------------------
// swmm_pkg: shared constants and types for the sliding window min/max block
// Default sizes, register indexes and the controller state type.
// ----------------------------------------------------------------------------
`default_nettype none
package swmm_pkg;
   localparam int unsigned DefMaxWindow   = 64;
   localparam int unsigned DefSampleWidth = 32;
   localparam int unsigned CsrDataWidth   = 7;
   localparam int unsigned CsrIndexWidth  = 1;

   localparam logic [CsrIndexWidth-1:0] CSR_WINDOW_LENGTH = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_TAKE_MINIMUM  = 1'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FIN
   } state_type;
endpackage
`default_nettype wire

FILE: hw/rtl/swmm_ram.sv
// ----------------------------------------------------------------------------
// swmm_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module swmm_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

FILE: hw/rtl/sliding_window_min_max_top.sv
// ----------------------------------------------------------------------------
// sliding_window_min_max_top: windowed minimum or maximum of a sample stream
// Keeps the last samples in a RAM and, once the window is full, scans it once per sample.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one sample per word: tdata = sample, tuser = {series_start,
//   sample_missing}. rsp_ returns one word per sample: tdata = extreme_value,
//   tuser = result_missing. csr_ writes window_length (index 0) and take_minimum
//   (index 1). The user writes them while the block is idle; it is not enforced.
//   Per sample the block writes the window RAM and, with a full window,
//   reads the other window_length-1 entries one per cycle over the RAM's
//   single read port, then goes through ST_DRAIN to ST_FIN; a short window
//   or L = 1 goes straight to ST_FIN. The result is loaded in ST_FIN and
//   the next sample is accepted in the cycle after it is loaded.
//   The result sits in an output register; while the receiver stalls the
//   block finishes the current scan and holds until the register frees.
//   Reset clears the write position, fill count and control state and sets
//   window_length to 1 and take_minimum to 1. RAM contents need no clearing:
//   only entries written since the series start are ever read.
// ----------------------------------------------------------------------------
`default_nettype none
module sliding_window_min_max_top
   import swmm_pkg::*;
#(
   parameter int unsigned MAX_WINDOW   = DefMaxWindow,
   parameter int unsigned SAMPLE_WIDTH = DefSampleWidth
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // [SAMPLE_WIDTH-1:0] sample, zero padded to bytes
   input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    req_tdata,
   // [0] sample_missing, [1] series_start
   input  wire logic [1:0]                           req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // [SAMPLE_WIDTH-1:0] extreme_value, zero padded to bytes
   output logic      [((SAMPLE_WIDTH+7)/8)*8-1:0]    rsp_tdata,
   // [0] result_missing
   output logic                                      rsp_tuser,
   input  wire logic                                 csr_wr_en,
   input  wire logic [CsrIndexWidth-1:0]             csr_index,
   input  wire logic [CsrDataWidth-1:0]              csr_wdata
);
   localparam int unsigned AW = $clog2(MAX_WINDOW);
   localparam int unsigned LW = $clog2(MAX_WINDOW + 1);
   localparam int unsigned DW = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam logic [AW-1:0] LastAddr = AW'(MAX_WINDOW - 1);
   localparam logic [LW-1:0] MaxLen   = LW'(MAX_WINDOW);

   state_type state_ff, state_in;

   logic [CsrDataWidth-1:0] window_length_ff;
   logic                    take_minimum_ff;
   logic [AW-1:0]           pos_ff;
   logic [LW-1:0]           fill_ff;
   logic [AW-1:0]           rd_addr_ff;
   logic [LW-1:0]           rem_ff;
   logic                    rd_vld_ff;
   logic                    min_ff;
   logic                    short_ff;
   logic                    found_ff;
   logic signed [SAMPLE_WIDTH-1:0] best_ff;
   logic                    rsp_valid_ff;
   logic [SAMPLE_WIDTH-1:0] rsp_value_ff;
   logic                    rsp_missing_ff;

   logic [LW-1:0]           len;
   logic [LW-1:0]           fill_in;
   logic                    accept;
   logic                    out_free;
   logic                    rd_en;
   logic [SAMPLE_WIDTH:0]   rd_data;
   logic signed [SAMPLE_WIDTH-1:0] rd_sample;
   logic                    better;
   logic                    res_missing;

   always_comb begin
      priority if (window_length_ff == '0) begin
         len = LW'(1);
      end else if (32'(window_length_ff) > MAX_WINDOW) begin
         len = MaxLen;
      end else begin
         len = LW'(window_length_ff);
      end
   end

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      priority if (req_tuser[1]) begin
         fill_in = LW'(1);
      end else if (fill_ff < MaxLen) begin
         fill_in = fill_ff + LW'(1);
      end else begin
         fill_in = fill_ff;
      end
   end

   swmm_ram #(.WIDTH(SAMPLE_WIDTH + 1), .DEPTH(MAX_WINDOW)) u_window_ram (
      .clock  (clock),
      .wr_en  (accept),
      .wr_addr(pos_ff),
      .wr_data({req_tuser[0], req_tdata[SAMPLE_WIDTH-1:0]}),
      .rd_en  (rd_en),
      .rd_addr(rd_addr_ff),
      .rd_data(rd_data)
   );

   assign rd_sample = $signed(rd_data[SAMPLE_WIDTH-1:0]);
   assign better    = min_ff ? (rd_sample < best_ff) : (rd_sample > best_ff);
   assign res_missing = short_ff || !found_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (fill_in < len || len == LW'(1)) ? ST_FIN : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rem_ff == LW'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_FIN;
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      rd_en      = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_SCAN:  rd_en      = 1'b1;
         ST_DRAIN: ;
         ST_FIN:   ;
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         window_length_ff <= CsrDataWidth'(1);
         take_minimum_ff  <= 1'b1;
         pos_ff           <= '0;
         fill_ff          <= '0;
         rd_vld_ff        <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_en;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_WINDOW_LENGTH: window_length_ff <= csr_wdata;
               CSR_TAKE_MINIMUM:  take_minimum_ff  <= csr_wdata[0];
               default: ;
            endcase
         end
         if (accept) begin
            pos_ff  <= (pos_ff == LastAddr) ? '0 : pos_ff + AW'(1);
            fill_ff <= fill_in;
         end
         if (state_ff == ST_FIN && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_addr_ff <= (pos_ff == '0) ? LastAddr : pos_ff - AW'(1);
         rem_ff     <= len - LW'(1);
         min_ff     <= take_minimum_ff;
         short_ff   <= fill_in < len;
         best_ff    <= $signed(req_tdata[SAMPLE_WIDTH-1:0]);
         found_ff   <= !req_tuser[0];
      end else begin
         if (rd_en) begin
            // walk back from the entry just before the newest
            rd_addr_ff <= (rd_addr_ff == '0) ? LastAddr : rd_addr_ff - AW'(1);
            rem_ff     <= rem_ff - LW'(1);
         end
         if (rd_vld_ff && !rd_data[SAMPLE_WIDTH] && (!found_ff || better)) begin
            best_ff  <= rd_sample;
            found_ff <= 1'b1;
         end
      end
      if (state_ff == ST_FIN && out_free) begin
         rsp_value_ff   <= res_missing ? '0 : best_ff;
         rsp_missing_ff <= res_missing;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DW'(rsp_value_ff);
   assign rsp_tuser  = rsp_missing_ff;
endmodule
`default_nettype wire
